// ===== rtl/ccfd_pkg.sv =====
// Shared constants, types and the CRC16 byte update for the frame deframer.
package ccfd_pkg;

  localparam int BYTE_W                = 8;
  localparam int CRC_W                 = 16;
  localparam int MAX_PAYLOAD_BYTES_DEF = 32;

  localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hAA;
  localparam logic [CRC_W-1:0]  CRC_INIT         = 16'hFFFF;
  localparam logic [CRC_W-1:0]  CRC_POLY         = 16'h1021;

  // Buffer bank handed back by the back end once its payload is drained
  typedef struct packed {
    logic valid;
    logic bank;
  } ccfd_release_t;

  // Advance CRC16-CCITT by one byte, MSB first, no reflection
  function automatic logic [CRC_W-1:0] crc16_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/ccfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ccfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ccfd_front.sv =====
// Front end: hunts for frames, tracks the CRC, buffers payload and queues frame jobs.
module ccfd_front import ccfd_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  parameter int LEN_W             = 6,
  parameter int IDX_W             = 5,
  parameter int JOB_W             = 1 + BYTE_W + LEN_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_valid,
  input  logic [BYTE_W-1:0] cfg_data,
  output logic              ram_we,
  output logic [IDX_W:0]    ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              push,
  output logic [JOB_W-1:0]  push_job,
  input  logic              q_full,
  input  ccfd_release_t     release_bank
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN    = 3'd1,
    PH_CMD    = 3'd2,
    PH_DATA   = 3'd3,
    PH_CRC_HI = 3'd4,
    PH_CRC_LO = 3'd5
  } phase_t;

  phase_t            phase;
  logic [BYTE_W-1:0] start_byte;
  logic [LEN_W-1:0]  length_held;
  logic [BYTE_W-1:0] command_held;
  logic [LEN_W-1:0]  payload_count;
  logic [CRC_W-1:0]  crc_running;
  logic [BYTE_W-1:0] crc_high;
  logic              wbank;
  logic [1:0]        busy;

  logic              accept;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W:0]    count_inc;
  logic [CRC_W-1:0]  crc_byte;
  logic [CRC_W-1:0]  crc_len;
  logic              crc_ok;
  logic              has_payload;
  logic [1:0]        busy_next;

  // Hold input while the fill bank is still draining or the job queue is full
  assign in_stall = ((phase == PH_DATA) && busy[wbank]) ||
                    ((phase == PH_CRC_LO) && q_full);
  assign accept   = in_valid && !in_stall;

  // Saturate the length byte to the payload maximum
  assign len_sat  = (int'(rx_byte) > MAX_PAYLOAD_BYTES) ? LEN_W'(MAX_PAYLOAD_BYTES)
                                                        : rx_byte[LEN_W-1:0];
  assign count_inc = {1'b0, payload_count} + 1'b1;
  assign crc_byte  = crc16_update(crc_running, rx_byte);
  assign crc_len   = crc16_update(CRC_INIT, BYTE_W'(len_sat));
  assign crc_ok    = ({crc_high, rx_byte} == crc_running);
  assign has_payload = crc_ok && (length_held != '0);

  // Payload write into the current fill bank
  assign ram_we    = accept && (phase == PH_DATA);
  assign ram_waddr = {wbank, payload_count[IDX_W-1:0]};
  assign ram_wdata = rx_byte;

  // Queue a job when the low CRC byte arrives
  assign push     = accept && (phase == PH_CRC_LO);
  assign push_job = {wbank, command_held, length_held, crc_ok};

  // Free a drained bank, pin the fill bank when its frame passes the CRC
  always_comb begin
    busy_next = busy;
    if (release_bank.valid) begin
      busy_next[release_bank.bank] = 1'b0;
    end
    if (push && has_payload) begin
      busy_next[wbank] = 1'b1;
    end
  end

  // Parser state, CRC and bank bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      start_byte    <= START_BYTE_RESET;
      length_held   <= '0;
      command_held  <= '0;
      payload_count <= '0;
      crc_running   <= CRC_INIT;
      crc_high      <= '0;
      wbank         <= 1'b0;
      busy          <= '0;
    end else begin
      if (cfg_valid) begin
        start_byte <= cfg_data;
      end
      busy <= busy_next;
      if (accept) begin
        case (phase)
          PH_LEN: begin
            length_held   <= len_sat;
            payload_count <= '0;
            crc_running   <= crc_len;
            phase         <= PH_CMD;
          end
          PH_CMD: begin
            command_held <= rx_byte;
            crc_running  <= crc_byte;
            phase        <= (length_held != '0) ? PH_DATA : PH_CRC_HI;
          end
          PH_DATA: begin
            payload_count <= count_inc[LEN_W-1:0];
            crc_running   <= crc_byte;
            if (count_inc >= {1'b0, length_held}) begin
              phase <= PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            crc_high <= rx_byte;
            phase    <= PH_CRC_LO;
          end
          PH_CRC_LO: begin
            // Flip to the other bank once this one is pinned for the back end
            if (has_payload) begin
              wbank <= ~wbank;
            end
            phase <= PH_HUNT;
          end
          default: begin
            phase <= (rx_byte == start_byte) ? PH_LEN : PH_HUNT;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/ccfd_queue.sv =====
// Two-entry job queue between the front end and the back end.
module ccfd_queue #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign pop_data = entry[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/ccfd_back.sv =====
// Back end: emits the header result of each job, then drains its payload bank.
module ccfd_back import ccfd_pkg::*; #(
  parameter int LEN_W = 6,
  parameter int IDX_W = 5,
  parameter int JOB_W = 1 + BYTE_W + LEN_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  logic [JOB_W-1:0]  q_job,
  output logic              q_pop,
  output logic              ram_re,
  output logic [IDX_W:0]    ram_raddr,
  input  logic [BYTE_W-1:0] ram_rdata,
  output ccfd_release_t     release_bank,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              is_header,
  output logic [BYTE_W-1:0] command,
  output logic [LEN_W-1:0]  length,
  output logic              crc_ok,
  output logic [BYTE_W-1:0] data_byte,
  output logic              last
);

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_READ = 2'd1,
    B_LOAD = 2'd2
  } bstate_t;

  bstate_t           state;
  logic              bank;
  logic [BYTE_W-1:0] cmd_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  idx;

  logic              job_bank;
  logic [BYTE_W-1:0] job_cmd;
  logic [LEN_W-1:0]  job_len;
  logic              job_ok;
  logic              can_load;
  logic              load_pay;
  logic [LEN_W:0]    idx_inc;
  logic              pay_last;

  assign {job_bank, job_cmd, job_len, job_ok} = q_job;

  // Output register is free when empty or being taken this cycle
  assign can_load = !out_valid || !out_stall;
  assign load_pay = (state == B_LOAD) && can_load;
  assign idx_inc  = {1'b0, idx} + 1'b1;
  assign pay_last = (idx_inc == {1'b0, len_r});

  assign q_pop     = (state == B_IDLE) && !q_empty && can_load;
  assign ram_re    = (state == B_READ);
  assign ram_raddr = {bank, idx[IDX_W-1:0]};

  assign release_bank.valid = load_pay && pay_last;
  assign release_bank.bank  = bank;

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      // Offer a new result on a load, keep a stalled one, else drop valid
      out_valid <= q_pop || load_pay || (out_valid && out_stall);
      case (state)
        B_IDLE: begin
          if (q_pop) begin
            is_header <= 1'b1;
            command   <= job_cmd;
            length    <= job_len;
            crc_ok    <= job_ok;
            data_byte <= '0;
            last      <= !job_ok || (job_len == '0);
            bank      <= job_bank;
            cmd_r     <= job_cmd;
            len_r     <= job_len;
            idx       <= '0;
            if (job_ok && (job_len != '0)) begin
              state <= B_READ;
            end
          end
        end
        B_READ: begin
          state <= B_LOAD;
        end
        B_LOAD: begin
          if (load_pay) begin
            is_header <= 1'b0;
            command   <= cmd_r;
            length    <= len_r;
            crc_ok    <= 1'b1;
            data_byte <= ram_rdata;
            last      <= pay_last;
            idx       <= idx_inc[LEN_W-1:0];
            state     <= pay_last ? B_IDLE : B_READ;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/crc_checked_frame_deframer_unit.sv =====
// Top level of the CRC-checked frame deframer.
//
// Input channel: in_valid / in_stall carry one received byte (rx_byte) per request.
// Frames are start byte, length (saturated to MAX_PAYLOAD_BYTES), command,
// payload and a big-endian CRC16-CCITT over length, command and payload.
// Output channel: out_valid / out_stall carry results. Each frame gives a
// header result (is_header = 1) with command, length and crc_ok; on a CRC match
// the payload bytes follow, and the final result of the run has last = 1.
// Configuration: cfg_valid / cfg_ready writes start_byte; cfg_ready is always high.
// Throughput: the front end takes one byte per cycle while in_stall is low. The
// header result is queued on the low CRC byte and leaves through the back-end
// output register; each payload byte then passes a RAM read state and an output
// load state. Payload sits in a two-bank RAM: the front end stalls input on a
// payload byte while its fill bank is still draining, and on the low CRC byte
// while the two-entry job queue is full.
// Reset (rst, synchronous) returns to hunting, restores start_byte to 0xAA
// and empties the queue. A stalled receiver holds the output register; the
// front end keeps parsing until buffering runs out.
module crc_checked_frame_deframer_unit import ccfd_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = MAX_PAYLOAD_BYTES_DEF,
  localparam int LEN_W = $clog2(MAX_PAYLOAD_BYTES + 1),
  localparam int IDX_W = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              is_header,
  output logic [BYTE_W-1:0] command,
  output logic [LEN_W-1:0]  length,
  output logic              crc_ok,
  output logic [BYTE_W-1:0] data_byte,
  output logic              last
);

  localparam int JOB_W     = 1 + BYTE_W + LEN_W + 1;
  localparam int RAM_DEPTH = 2 << IDX_W;

  logic              ram_we;
  logic [IDX_W:0]    ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W:0]    ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic              push;
  logic [JOB_W-1:0]  push_job;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;
  logic [JOB_W-1:0]  q_job;
  ccfd_release_t     release_bank;

  assign cfg_ready = 1'b1;

  // Parse and buffer
  ccfd_front #(
    .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES),
    .LEN_W(LEN_W),
    .IDX_W(IDX_W),
    .JOB_W(JOB_W)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .cfg_valid(cfg_valid),
    .cfg_data(cfg_data),
    .ram_we(ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .push(push),
    .push_job(push_job),
    .q_full(q_full),
    .release_bank(release_bank)
  );

  // Two-bank payload buffer
  ccfd_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re(ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Frame job queue
  ccfd_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_job),
    .full(q_full),
    .pop(q_pop),
    .empty(q_empty),
    .pop_data(q_job)
  );

  // Emit results
  ccfd_back #(
    .LEN_W(LEN_W),
    .IDX_W(IDX_W),
    .JOB_W(JOB_W)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_job(q_job),
    .q_pop(q_pop),
    .ram_re(ram_re),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .release_bank(release_bank),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .is_header(is_header),
    .command(command),
    .length(length),
    .crc_ok(crc_ok),
    .data_byte(data_byte),
    .last(last)
  );

endmodule

// ===== rtl/ccfd_checker.sv =====
// Port-level checks on the deframer's result stream, bound to the top level.
module ccfd_checker #(
  parameter int LEN_W = 6
) (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_stall,
  input logic             is_header,
  input logic [LEN_W-1:0] length,
  input logic             crc_ok,
  input logic             last
);

  // A stalled result stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // Payload results only follow a good CRC
  a_payload_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_header |-> crc_ok && (length != '0))
    else $error("payload result without good CRC or length");

  // A failed or empty frame ends at its header
  a_header_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_header && (!crc_ok || (length == '0)) |-> last)
    else $error("header of failed or empty frame not marked last");

  // A good non-empty header is never the last result
  a_header_more: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_header && crc_ok && (length != '0) |-> !last)
    else $error("header marked last although payload follows");

endmodule

bind crc_checked_frame_deframer_unit ccfd_checker #(.LEN_W(LEN_W)) u_ccfd_checker (.*);
